// ===== rtl/core/stwq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer wakeup queue package
// Shared types, sizes and helper functions of the sorted timer wakeup queue.
// ----------------------------------------------------------------------------
package stwq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W       = $clog2(DEPTH + 1);
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned AMT_W       = 24;
  localparam int unsigned WAIT_W      = 5;

  localparam logic KIND_PAUSE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    STAT_WOKEN = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ZERO  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_TICK
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   sleeper_id;
    logic [AMT_W-1:0]  amount;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   woken_id;
    logic [WAIT_W-1:0] waiting;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Circular slot pointer arithmetic that works for any depth.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == '0) r = IDX_W'(DEPTH - 1);
    else r = p - 1'b1;
    return r;
  endfunction

  // Occupancy as reported in a result beat, masked to the field width.
  function automatic logic [WAIT_W-1:0] to_wait(input logic [OCC_W-1:0] occ);
    logic [OCC_W+WAIT_W-1:0] ext;
    ext = {{WAIT_W{1'b0}}, occ};
    return ext[WAIT_W-1:0];
  endfunction

  // Saturating add of a duration to a time value.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [AMT_W-1:0]  b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - AMT_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sorted_timer_wakeup_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer wakeup queue
// Time counter plus a wake-time ordered table of sleepers kept in one RAM.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start while busy is low to hand over one beat.
// A pause beat inserts a sleeper at wake time now + amount (saturating). It
// keeps busy high while each queued sleeper with a strictly later wake time
// moves up one slot and while the new entry is written, and gives no result.
// A pause with zero amount or against a full table is answered on the
// following cycle with one reject beat and no busy time at all. A tick beat
// advances the time counter and then releases due sleepers at one per cycle,
// earliest first, with last set on the final one. It keeps busy high until
// the head entry read is not due or the table has run empty, or not at all
// when the table is empty, and its final release beat shows in the first
// cycle with busy low. Busy time comes from the single read and single write
// port of the table RAM, which is walked one entry per cycle. Result beats
// appear on rsp_o for exactly one cycle, marked by rsp_valid_o, and cannot be
// held off; a new beat may be started while the final result of the previous
// one is still being shown. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_timer_wakeup_queue
  import stwq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  // The table is a circular buffer: head_q is the earliest sleeper, tail_q
  // the first free slot, and occ_q tells full from empty when they meet.
  entry_t mem [DEPTH];
  entry_t rd_data_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  state_e            state_q, state_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [IDX_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [OCC_W-1:0]  k_q, k_d;
  entry_t            new_q, new_d;
  logic              pend_q, pend_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic [OCC_W-1:0]  pend_wait_q, pend_wait_d;
  logic [CNT_W-1:0]  rel_cnt_q, rel_cnt_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              accept;
  logic              is_full;
  logic              zero_amt;
  logic              shift_up;
  logic              expire;
  logic [TIME_W-1:0] tick_now;

  assign accept   = start && (state_q == S_IDLE);
  assign is_full  = (occ_q == OCC_W'(DEPTH));
  assign zero_amt = (req_i.amount == '0);
  assign tick_now = sat_add(now_q, req_i.amount);
  // During insertion, an entry later than the new one moves up one slot.
  assign shift_up = (rd_data_q.wake > new_q.wake);
  // During a tick, the entry just read at the head is due for release.
  assign expire   = (occ_q != '0) && (rd_data_q.wake <= now_q) &&
                    (rel_cnt_q < CNT_W'(MAX_RESULTS));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_TICK) begin
            if (occ_q != '0) state_d = S_TICK;
          end else if (!zero_amt && !is_full) begin
            state_d = (occ_q == '0) ? S_INS_PUT : S_INS;
          end
        end
      end
      S_INS: begin
        if (shift_up) begin
          if (k_q == OCC_W'(1)) state_d = S_INS_PUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_INS_PUT: state_d = S_IDLE;
      S_TICK: begin
        if (!expire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM access and result beats.
  always_comb begin
    now_d       = now_q;
    occ_d       = occ_q;
    head_d      = head_q;
    tail_d      = tail_q;
    wr_ptr_d    = wr_ptr_q;
    k_d         = k_q;
    new_d       = new_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    pend_wait_d = pend_wait_q;
    rel_cnt_d   = rel_cnt_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr_q;
    mem_wdata   = new_q;
    mem_raddr   = head_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_TICK) begin
            now_d     = tick_now;
            mem_raddr = head_q;
            rel_cnt_d = '0;
            pend_d    = 1'b0;
          end else if (zero_amt || is_full) begin
            rsp_valid_d    = 1'b1;
            rsp_d.status   = zero_amt ? STAT_ZERO : STAT_FULL;
            rsp_d.woken_id = req_i.sleeper_id;
            rsp_d.waiting  = to_wait(occ_q);
            rsp_d.last     = 1'b1;
          end else begin
            new_d.wake = sat_add(now_q, req_i.amount);
            new_d.id   = req_i.sleeper_id;
            wr_ptr_d   = tail_q;
            k_d        = occ_q;
            mem_raddr  = idx_dec(tail_q);
          end
        end
      end
      S_INS: begin
        // rd_data_q holds the slot just below wr_ptr_q.
        mem_we = 1'b1;
        if (shift_up) begin
          mem_wdata = rd_data_q;
          wr_ptr_d  = idx_dec(wr_ptr_q);
          k_d       = k_q - 1'b1;
          mem_raddr = idx_dec(idx_dec(wr_ptr_q));
        end else begin
          mem_wdata = new_q;
          occ_d     = occ_q + 1'b1;
          tail_d    = idx_inc(tail_q);
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = new_q;
        occ_d     = occ_q + 1'b1;
        tail_d    = idx_inc(tail_q);
      end
      S_TICK: begin
        // A release is held in pend_q so that last is known when it is sent.
        if (pend_q) begin
          rsp_valid_d    = 1'b1;
          rsp_d.status   = STAT_WOKEN;
          rsp_d.woken_id = pend_id_q;
          rsp_d.waiting  = to_wait(pend_wait_q);
          rsp_d.last     = !expire;
        end
        if (expire) begin
          pend_d      = 1'b1;
          pend_id_d   = rd_data_q.id;
          pend_wait_d = occ_q - 1'b1;
          occ_d       = occ_q - 1'b1;
          head_d      = idx_inc(head_q);
          rel_cnt_d   = rel_cnt_q + 1'b1;
          mem_raddr   = idx_inc(head_q);
        end else begin
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      occ_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      pend_q      <= 1'b0;
      rel_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      occ_q       <= occ_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pend_q      <= pend_d;
      rel_cnt_q   <= rel_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_ptr_q    <= wr_ptr_d;
    k_q         <= k_d;
    new_q       <= new_d;
    pend_id_q   <= pend_id_d;
    pend_wait_q <= pend_wait_d;
    rsp_q       <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/core/stwq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer wakeup queue checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module stwq_checker
  import stwq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // A zero-duration pause is answered on the next cycle with a final reject.
  a_zero_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.kind == KIND_PAUSE && req_i.amount == '0) |=>
    (rsp_valid_o && rsp_o.status == STAT_ZERO && rsp_o.last))
    else $error("zero-duration pause not rejected");

  // Rejects are always single, final beats.
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != STAT_WOKEN) |-> rsp_o.last)
    else $error("reject beat without last");

  // Releases of one tick come back to back, each one leaving one fewer.
  a_release_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == STAT_WOKEN && !rsp_o.last) |=>
    (rsp_valid_o && rsp_o.status == STAT_WOKEN &&
     rsp_o.waiting == $past(rsp_o.waiting) - 1'b1))
    else $error("release chain broken");

  // A non-final release never shows while the block is idle.
  a_chain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.last) |-> busy)
    else $error("non-final release while idle");

endmodule

bind sorted_timer_wakeup_queue stwq_checker u_stwq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

// ===== test/stwq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer wakeup queue checker
// Watches the request and result channels and keeps its own copy of the time
// counter and the sleeper table. Every accepted request is turned into the
// result beats it should cause, and every result beat is compared with them.
// ----------------------------------------------------------------------------
module stwq_tb_checker
  import stwq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic rsp_valid_i,
  input  rsp_t rsp_i,
  output int   pending_o,
  output int   errors_o
);

  logic [TIME_W-1:0] clock_now = '0;
  entry_t            sleepers[$];
  rsp_t              awaited[$];

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  // Wake or clock time plus a duration, pinned at the top of the time range.
  function automatic logic [TIME_W-1:0] time_plus(input logic [TIME_W-1:0] t,
                                                  input logic [AMT_W-1:0]  d);
    logic [TIME_W-1:0] headroom;
    headroom = ~t;
    if (TIME_W'(d) > headroom) return '1;
    return t + TIME_W'(d);
  endfunction

  task automatic predict_beat(input req_t beat);
    rsp_t              res;
    rsp_t              held;
    entry_t            ent;
    logic [TIME_W-1:0] due;
    int                pos;
    int                released;
    if (beat.kind == KIND_PAUSE) begin
      res.woken_id = beat.sleeper_id;
      res.waiting  = WAIT_W'(sleepers.size());
      res.last     = 1'b1;
      if (beat.amount == '0) begin
        res.status = STAT_ZERO;
        awaited.push_back(res);
      end else if (sleepers.size() >= DEPTH) begin
        res.status = STAT_FULL;
        awaited.push_back(res);
      end else begin
        // Equal wake times keep arrival order: go past every entry not later.
        due = time_plus(clock_now, beat.amount);
        pos = 0;
        while (pos < sleepers.size() && sleepers[pos].wake <= due) pos++;
        ent.wake = due;
        ent.id   = beat.sleeper_id;
        sleepers.insert(pos, ent);
      end
    end else begin
      clock_now = time_plus(clock_now, beat.amount);
      released  = 0;
      while (released < MAX_RESULTS && sleepers.size() > 0 &&
             sleepers[0].wake <= clock_now) begin
        if (released > 0) awaited.push_back(held);
        held.status   = STAT_WOKEN;
        held.woken_id = sleepers[0].id;
        sleepers.pop_front();
        held.waiting  = WAIT_W'(sleepers.size());
        held.last     = 1'b0;
        released++;
      end
      if (released > 0) begin
        held.last = 1'b1;
        awaited.push_back(held);
      end
    end
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (awaited.size() == 0) begin
      $error("result beat with nothing awaited: status %0d id 0x%02h",
             got.status, got.woken_id);
      errors_o++;
    end else begin
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors_o++;
      end
      if (got.woken_id !== want.woken_id) begin
        $error("woken_id: expected 0x%02h, got 0x%02h", want.woken_id, got.woken_id);
        errors_o++;
      end
      if (got.waiting !== want.waiting) begin
        $error("waiting: expected %0d, got %0d", want.waiting, got.waiting);
        errors_o++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors_o++;
      end
    end
  endtask

  // Results are checked before the new request is predicted, so a result of
  // the previous beat shown on the accept edge still meets its own entry.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_i) check_result(rsp_i);
      if (start_i && !busy_i) predict_beat(req_i);
      pending_o = awaited.size();
    end
  end

endmodule

// ===== test/tb_sorted_timer_wakeup_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer wakeup queue testbench
// Drives pause and tick beats into the queue, first a directed set that hits
// rejects, equal wake times and a full release, then random traffic, then a
// run of large ticks mixed with far pauses. The checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_sorted_timer_wakeup_queue
  import stwq_pkg::*;
;

  // Random traffic length and the quiet-cycle limit of the watchdog. The
  // slowest beat keeps the block busy while it walks the whole table, a
  // sender gap is capped at MAX_GAP and the closing wait is TAIL_CYCLES,
  // so reaching QUIET_LIMIT means the block is stuck.
  localparam int RANDOM_BEATS = 100;
  localparam int MAX_GAP      = 6;
  localparam int TAIL_CYCLES  = 40;
  localparam int QUIET_LIMIT  = 500;
  localparam int SAT_TICKS    = 35;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic start       = 1'b0;
  req_t req_i       = '0;
  logic busy;
  logic rsp_valid_o;
  rsp_t rsp_o;

  int   pending;
  int   errors;
  int   quiet_cycles = 0;
  bit   steady       = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_timer_wakeup_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  stwq_tb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .rsp_valid_i (rsp_valid_o),
    .rsp_i       (rsp_o),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Watchdog: any accepted request or result beat counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || rsp_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_sorted_timer_wakeup_queue: errors");
      $finish;
    end
  end

  function automatic req_t mk_beat(input logic kind, input logic [ID_W-1:0] id,
                                   input logic [AMT_W-1:0] amt);
    req_t beat;
    beat.kind       = kind;
    beat.sleeper_id = id;
    beat.amount     = amt;
    return beat;
  endfunction

  // Pauses are mostly short so that ticks release them soon, with the odd
  // zero duration and the odd full-range duration.
  function automatic req_t pause_beat();
    int               pick;
    logic [AMT_W-1:0] amt;
    pick = $urandom_range(99);
    if (pick < 5) amt = '0;
    else if (pick < 10) amt = AMT_W'($urandom);
    else amt = AMT_W'($urandom_range(1, 64));
    return mk_beat(KIND_PAUSE, ID_W'($urandom), amt);
  endfunction

  // Ticks mostly advance a little; some are zero, some jump far ahead and
  // empty the table in one go. The id travels along as noise.
  function automatic req_t tick_beat();
    int               pick;
    logic [AMT_W-1:0] amt;
    pick = $urandom_range(99);
    if (pick < 10) amt = '0;
    else if (pick < 80) amt = AMT_W'($urandom_range(1, 32));
    else if (pick < 95) amt = AMT_W'($urandom_range(33, 300));
    else amt = AMT_W'($urandom);
    return mk_beat(KIND_TICK, ID_W'($urandom), amt);
  endfunction

  // Hands one beat over. Outside steady stretches the sender may idle first,
  // showing junk on the request bus while start is low.
  // Returns on the edge that accepted the beat, with start still high.
  task automatic send_beat(input req_t beat);
    int gap;
    gap = 0;
    while (!steady && gap < MAX_GAP && $urandom_range(99) < 28) begin
      start <= 1'b0;
      req_i <= {1'($urandom), ID_W'($urandom), AMT_W'($urandom)};
      @(posedge clk_i);
      gap++;
    end
    req_i <= beat;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Holds the sender off until every awaited result beat has shown up. The
  // count is read at the falling edge, clear of the checker's updates.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int ticks;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A zero tick on an empty table releases nobody, then a
    // zero-duration pause is rejected.
    send_beat(mk_beat(KIND_TICK, 8'h00, 24'h000000));
    send_beat(mk_beat(KIND_PAUSE, 8'hFF, 24'h000000));
    // Longest possible pause, then two sleepers sharing a wake time which
    // must come out in arrival order.
    send_beat(mk_beat(KIND_PAUSE, 8'h00, 24'hFFFFFF));
    send_beat(mk_beat(KIND_PAUSE, 8'h81, 24'h000001));
    send_beat(mk_beat(KIND_PAUSE, 8'h42, 24'h000001));
    send_beat(mk_beat(KIND_TICK, 8'hFF, 24'h000000));
    send_beat(mk_beat(KIND_TICK, 8'hAA, 24'h000001));
    // Fill the table up, then try one more pause: a full-table reject. A
    // zero duration against the full table must still report zero duration.
    for (int k = 0; k < DEPTH - 1; k++) begin
      send_beat(mk_beat(KIND_PAUSE, ID_W'(8'h10 + k), AMT_W'($urandom_range(2, 40))));
    end
    send_beat(mk_beat(KIND_PAUSE, 8'hEE, 24'h000007));
    send_beat(mk_beat(KIND_PAUSE, 8'h77, 24'h000000));
    // One big tick releases the whole table, the most a tick can give.
    send_beat(mk_beat(KIND_TICK, 8'h55, 24'hFFFFFF));
    hold_until_drained();

    // Random traffic with a steady stretch from beat sixty to the end and a full
    // drain every forty beats.
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      steady = (k >= 60 && k < 110);
      if (k % 40 == 39) hold_until_drained();
      if ($urandom_range(99) < 55) send_beat(pause_beat());
      else send_beat(tick_beat());
    end
    hold_until_drained();

    // Move the time counter far ahead with near-maximal ticks. Pauses in
    // between get far wake times, which the next large tick or the one
    // after it already reaches.
    ticks = 0;
    while (ticks < SAT_TICKS) begin
      if ($urandom_range(99) < 25) begin
        send_beat(mk_beat(KIND_PAUSE, ID_W'($urandom),
                          AMT_W'($urandom_range(1, 24'hFFFFFF))));
      end else begin
        send_beat(mk_beat(KIND_TICK, ID_W'($urandom),
                          AMT_W'(24'hFFFFFF - $urandom_range(3))));
        ticks++;
      end
    end

    // Let the last results arrive and give a trailing pause insert time to
    // finish before the verdict.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_sorted_timer_wakeup_queue: clean");
    end else begin
      $display("tb_sorted_timer_wakeup_queue: errors");
    end
    $finish;
  end

endmodule
